### hw/rtl/ppghr_pkg.sv
// Package for the PPG heart-rate beat detector: widths, register indexes,
// controller states, command/status structs and small arithmetic helpers.
// No dependencies.
`default_nettype none

package ppghr_pkg;

   localparam int SAMPLE_WIDTH = 18;
   localparam int IR_W         = 18;
   localparam int DC_W         = SAMPLE_WIDTH + 8;
   localparam int AC_W         = SAMPLE_WIDTH + 1;
   localparam int MAG_W        = SAMPLE_WIDTH + 1;
   localparam int SLOPE_W      = SAMPLE_WIDTH + 2;
   localparam int THR_W        = SAMPLE_WIDTH + 2;
   localparam int LEVEL_W      = 16;
   localparam int LVL_CMP_W    = (MAG_W > LEVEL_W) ? MAG_W : LEVEL_W;
   localparam int MIN_INTV_W   = 8;
   localparam int INTV_W       = 10;
   localparam int COUNT_W      = 32;
   localparam int RATE_W       = 16;
   localparam int HR_W         = 8;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;
   localparam int QUOT_W       = 13;
   localparam int DIV_CNT_W    = $clog2(QUOT_W + 1);

   localparam logic [QUOT_W-1:0]     RATE_NUMERATOR = QUOT_W'(6000);
   localparam logic [MIN_INTV_W-1:0] MIN_INTV_RESET = MIN_INTV_W'(35);
   localparam logic [INTV_W-1:0]     MAX_INTV_RESET = INTV_W'(200);
   localparam logic [LEVEL_W-1:0]    LEVEL_RESET    = LEVEL_W'(25);
   localparam logic [THR_W-1:0]      THR_MAG_OFFSET   = THR_W'(8);
   localparam logic [THR_W-1:0]      SLOPE_LIM_OFFSET = THR_W'(4);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_BEAT_INTERVAL = 2'd0,
      CSR_MAX_BEAT_INTERVAL = 2'd1,
      CSR_MIN_SIGNAL_LEVEL  = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILTER,
      ST_AC,
      ST_AVG,
      ST_THR,
      ST_DETECT,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_RATE,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic load_sample;
      logic filter;
      logic ac;
      logic avg;
      logic thr;
      logic detect;
      logic div_start;
      logic rate;
      logic out_load;
   } ppghr_cmd_type;

   typedef struct packed {
      logic found;
      logic div_busy;
   } ppghr_sts_type;

   function automatic logic [SAMPLE_WIDTH-1:0] sample_of(input logic [IR_W-1:0] v);
      logic [SAMPLE_WIDTH+IR_W-1:0] t;
      t = {{SAMPLE_WIDTH{1'b0}}, v};
      return t[SAMPLE_WIDTH-1:0];
   endfunction

   function automatic logic [AC_W-1:0] mag_ac(input logic signed [AC_W-1:0] v);
      return v[AC_W-1] ? AC_W'(-v) : AC_W'(v);
   endfunction

   function automatic logic [AC_W:0] mag_diff(input logic signed [AC_W:0] v);
      return v[AC_W] ? (AC_W+1)'(-v) : (AC_W+1)'(v);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/ppghr_ctrl.sv
// Controller state machine of the PPG beat detector: sequences the datapath
// steps per request and owns the request/result handshake. Uses ppghr_pkg.
`default_nettype none

module ppghr_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire ppghr_pkg::ppghr_sts_type sts,
   output ppghr_pkg::ppghr_cmd_type     cmd
);
   import ppghr_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_FILTER;
         ST_FILTER:    state_in = ST_AC;
         ST_AC:        state_in = ST_AVG;
         ST_AVG:       state_in = ST_THR;
         ST_THR:       state_in = ST_DETECT;
         ST_DETECT:    state_in = sts.found ? ST_DIV_START : ST_DONE;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:  if (!sts.div_busy) state_in = ST_RATE;
         ST_RATE:      state_in = ST_DONE;
         ST_DONE:      if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE:      cmd.load_sample = req_valid;
         ST_FILTER:    cmd.filter      = 1'b1;
         ST_AC:        cmd.ac          = 1'b1;
         ST_AVG:       cmd.avg         = 1'b1;
         ST_THR:       cmd.thr         = 1'b1;
         ST_DETECT:    cmd.detect      = 1'b1;
         ST_DIV_START: cmd.div_start   = 1'b1;
         ST_DIV_WAIT:  cmd             = '0;
         ST_RATE:      cmd.rate        = 1'b1;
         ST_DONE:      cmd.out_load    = out_free;
         default:      cmd             = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/ppghr_div.sv
// Restoring divider of the PPG beat detector: one quotient bit per cycle of
// the fixed rate numerator by the beat interval. Uses ppghr_pkg.
`default_nettype none

module ppghr_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [ppghr_pkg::INTV_W-1:0]   divisor,
   output logic                                busy,
   output logic      [ppghr_pkg::QUOT_W-1:0]   quotient
);
   import ppghr_pkg::*;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [INTV_W-1:0]    rem_ff, rem_in;
   logic [INTV_W-1:0]    dvs_ff, dvs_in;
   logic [QUOT_W-1:0]    dvd_ff, dvd_in;
   logic [INTV_W:0]      trial;
   logic                 fits;

   assign trial    = {rem_ff, dvd_ff[QUOT_W-1]};
   assign fits     = (trial >= {1'b0, dvs_ff});
   assign busy     = busy_ff;
   assign quotient = dvd_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      dvd_in  = dvd_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(QUOT_W);
         rem_in  = '0;
         dvs_in  = divisor;
         dvd_in  = RATE_NUMERATOR;
      end else if (busy_ff) begin
         rem_in  = fits ? INTV_W'(trial - {1'b0, dvs_ff}) : trial[INTV_W-1:0];
         dvd_in  = {dvd_ff[QUOT_W-2:0], fits};
         cnt_in  = cnt_ff - DIV_CNT_W'(1);
         busy_in = (cnt_ff != DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      dvd_ff <= dvd_in;
   end

endmodule

`default_nettype wire

### hw/rtl/ppghr_dp.sv
// Datapath of the PPG beat detector: DC removal, magnitude and slope averages,
// thresholds, peak gating, interval check, rate smoothing and result register.
// Uses ppghr_pkg and ppghr_div.
`default_nettype none

module ppghr_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ppghr_pkg::ppghr_cmd_type          cmd,
   output ppghr_pkg::ppghr_sts_type               sts,
   input  wire logic      [ppghr_pkg::IR_W-1:0]   req_ir_sample,
   input  wire logic                              csr_we,
   input  wire logic      [ppghr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic      [ppghr_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                                   rsp_beat_found,
   output logic           [ppghr_pkg::HR_W-1:0]   rsp_heart_rate
);
   import ppghr_pkg::*;

   // configuration
   logic [MIN_INTV_W-1:0] min_intv_ff;
   logic [INTV_W-1:0]     max_intv_ff;
   logic [LEVEL_W-1:0]    level_ff;

   // per-request working registers
   logic [SAMPLE_WIDTH-1:0]  sample_ff;
   logic signed [AC_W-1:0]   x_ff, x_in;
   logic [THR_W-1:0]         thr_mag_ff, thr_mag_in;
   logic [THR_W-1:0]         slope_lim_ff, slope_lim_in;
   logic [AC_W-1:0]          abs_p_ff;
   logic [AC_W:0]            abs_ppd_ff, abs_pxd_ff;
   logic                     peak_ff, peak_in;
   logic                     level_ok_ff, level_ok_in;
   logic                     intv_ok_ff, intv_ok_in;
   logic [INTV_W-1:0]        divisor_ff;
   logic                     found_ff;
   logic [HR_W-1:0]          rate_out_ff;
   logic                     rsp_found_ff;
   logic [HR_W-1:0]          rsp_rate_ff;

   // detector state
   logic [DC_W-1:0]          dc_ff, dc_in;
   logic signed [AC_W-1:0]   last_ac_ff, older_ac_ff;
   logic [MAG_W-1:0]         mavg_ff, mavg_in;
   logic [SLOPE_W-1:0]       savg_ff, savg_in;
   logic                     armed_ff, armed_in;
   logic [COUNT_W-1:0]       count_ff;
   logic [COUNT_W-1:0]       last_beat_ff;
   logic [RATE_W-1:0]        rate_sm_ff, rate_sm_in;
   logic                     seeded_ff;

   // combinational helpers
   logic [DC_W-1:0]          target, dc_seed;
   logic signed [DC_W:0]     dc_diff, dc_sum;
   logic signed [AC_W:0]     dx, d_ppd, d_pxd;
   logic [COUNT_W-1:0]       ds;
   logic [MAG_W+1:0]         mavg_x3;
   logic                     gate, armed_after;
   logic [QUOT_W-1:0]        bpm;
   logic                     div_busy;

   ppghr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (divisor_ff),
      .busy     (div_busy),
      .quotient (bpm)
   );

   // DC level
   always_comb begin
      target  = {sample_ff, 8'b0};
      dc_seed = (dc_ff == '0) ? target : dc_ff;
      dc_diff = $signed({1'b0, target}) - $signed({1'b0, dc_seed});
      dc_sum  = $signed({1'b0, dc_seed}) + (dc_diff >>> 5);
      dc_in   = dc_sum[DC_W-1:0];
   end

   assign x_in = $signed({1'b0, sample_ff}) - $signed({1'b0, dc_ff[DC_W-1:8]});

   // averages
   always_comb begin
      dx      = $signed({x_ff[AC_W-1], x_ff}) - $signed({last_ac_ff[AC_W-1], last_ac_ff});
      mavg_in = mavg_ff - (mavg_ff >> 4) + MAG_W'(mag_ac(x_ff) >> 4);
      savg_in = savg_ff - (savg_ff >> 4) + SLOPE_W'(mag_diff(dx) >> 4);
   end

   // thresholds, peak shape and interval
   always_comb begin
      mavg_x3      = {2'b0, mavg_ff} + {1'b0, mavg_ff, 1'b0};
      thr_mag_in   = THR_W'(mavg_x3 >> 2) + THR_MAG_OFFSET;
      slope_lim_in = THR_W'(savg_ff >> 1) + SLOPE_LIM_OFFSET;
      d_ppd        = $signed({last_ac_ff[AC_W-1], last_ac_ff})
                   - $signed({older_ac_ff[AC_W-1], older_ac_ff});
      d_pxd        = $signed({last_ac_ff[AC_W-1], last_ac_ff})
                   - $signed({x_ff[AC_W-1], x_ff});
      peak_in      = ((last_ac_ff > older_ac_ff) && (last_ac_ff > x_ff))
                  || ((last_ac_ff < older_ac_ff) && (last_ac_ff < x_ff));
      level_ok_in  = (LVL_CMP_W'(mavg_ff) > LVL_CMP_W'(level_ff));
      ds           = count_ff - last_beat_ff;
      intv_ok_in   = (last_beat_ff != '0) && (ds != '0)
                  && (ds >= COUNT_W'(min_intv_ff)) && (ds <= COUNT_W'(max_intv_ff));
   end

   // beat decision and re-arm
   always_comb begin
      gate = armed_ff && level_ok_ff && peak_ff
          && ({1'b0, abs_p_ff} > thr_mag_ff)
          && (abs_ppd_ff > slope_lim_ff)
          && (abs_pxd_ff > slope_lim_ff);
      armed_after = gate ? 1'b0 : armed_ff;
      armed_in    = armed_after || ({1'b0, abs_p_ff} < (thr_mag_ff >> 2));
   end

   assign sts.found    = gate && intv_ok_ff;
   assign sts.div_busy = div_busy;

   // rate smoothing
   always_comb begin
      if (seeded_ff) begin
         rate_sm_in = rate_sm_ff - (rate_sm_ff >> 2) + {bpm[9:0], 6'b0};
      end else begin
         rate_sm_in = {bpm[7:0], 8'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_intv_ff <= MIN_INTV_RESET;
         max_intv_ff <= MAX_INTV_RESET;
         level_ff    <= LEVEL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_BEAT_INTERVAL: min_intv_ff <= csr_wdata[MIN_INTV_W-1:0];
            CSR_MAX_BEAT_INTERVAL: max_intv_ff <= csr_wdata[INTV_W-1:0];
            CSR_MIN_SIGNAL_LEVEL:  level_ff    <= csr_wdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_ff        <= '0;
         last_ac_ff   <= '0;
         older_ac_ff  <= '0;
         mavg_ff      <= '0;
         savg_ff      <= '0;
         armed_ff     <= 1'b1;
         count_ff     <= '0;
         last_beat_ff <= '0;
         rate_sm_ff   <= '0;
         seeded_ff    <= 1'b0;
      end else begin
         if (cmd.filter) dc_ff <= dc_in;
         if (cmd.avg) begin
            mavg_ff  <= mavg_in;
            savg_ff  <= savg_in;
            count_ff <= count_ff + COUNT_W'(1);
         end
         if (cmd.detect) begin
            if (gate) last_beat_ff <= count_ff;
            armed_ff    <= armed_in;
            older_ac_ff <= last_ac_ff;
            last_ac_ff  <= x_ff;
         end
         if (cmd.rate) begin
            rate_sm_ff <= rate_sm_in;
            seeded_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_sample) sample_ff <= sample_of(req_ir_sample);
      if (cmd.ac) x_ff <= x_in;
      if (cmd.thr) begin
         thr_mag_ff   <= thr_mag_in;
         slope_lim_ff <= slope_lim_in;
         abs_p_ff     <= mag_ac(last_ac_ff);
         abs_ppd_ff   <= mag_diff(d_ppd);
         abs_pxd_ff   <= mag_diff(d_pxd);
         peak_ff      <= peak_in;
         level_ok_ff  <= level_ok_in;
         intv_ok_ff   <= intv_ok_in;
         divisor_ff   <= ds[INTV_W-1:0];
      end
      if (cmd.detect) begin
         found_ff    <= gate && intv_ok_ff;
         rate_out_ff <= '0;
      end
      if (cmd.rate) rate_out_ff <= rate_sm_in[RATE_W-1 -: HR_W];
      if (cmd.out_load) begin
         rsp_found_ff <= found_ff;
         rsp_rate_ff  <= rate_out_ff;
      end
   end

   assign rsp_beat_found = rsp_found_ff;
   assign rsp_heart_rate = rsp_rate_ff;

endmodule

`default_nettype wire

### hw/rtl/ppg_heart_rate_beat_detector.sv
// Top level of the PPG beat detector and heart-rate estimator.
// Joins the controller (ppghr_ctrl) and the datapath (ppghr_dp). Uses ppghr_pkg.
//
//   port group   direction   handshake            payload
//   req_         in          req_valid/req_stall  ir_sample
//   rsp_         out         rsp_valid/rsp_stall  beat_found, heart_rate
//   csr_         in          csr_we               csr_index, csr_wdata
//
// Until its result is in the output register a request holds req_stall; it passes the
// filter, AC, average, threshold and detect steps, and a beat with a valid interval adds
// the serial divider, one quotient bit per cycle (13 bits), and the rate step.
// Synchronous active-high reset restores the register defaults and detector state.
// A new request is taken while an earlier result still waits under rsp_stall.
`default_nettype none

module ppg_heart_rate_beat_detector (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [ppghr_pkg::IR_W-1:0]            req_ir_sample,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_beat_found,
   output logic      [ppghr_pkg::HR_W-1:0]            rsp_heart_rate,
   input  wire logic                                  csr_we,
   input  wire logic [ppghr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [ppghr_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import ppghr_pkg::*;

   ppghr_cmd_type cmd;
   ppghr_sts_type sts;

   ppghr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ppghr_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_ir_sample  (req_ir_sample),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_beat_found (rsp_beat_found),
      .rsp_heart_rate (rsp_heart_rate)
   );

endmodule

`default_nettype wire
